### hdl/olio_pkg.sv
// ----------------------------------------------------------------------------
// olio_pkg
// Shared types and codes for the ordered list with index operations.
// ----------------------------------------------------------------------------
`default_nettype none

package olio_pkg;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 5;
  localparam int unsigned TOTAL_W  = 5;

  localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_HEAD = 3'd0,
    ACT_INS_AT   = 3'd1,
    ACT_DEL_HEAD = 3'd2,
    ACT_DEL_AT   = 3'd3,
    ACT_SEARCH   = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic match;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic hit;
    logic none;
  } sts_t;

endpackage

`default_nettype wire

### hdl/olio_ctrl.sv
// ----------------------------------------------------------------------------
// olio_ctrl
// Sequencer: capture a request, apply it or run the search scan, pulse done.
// ----------------------------------------------------------------------------
`default_nettype none

module olio_ctrl
  import olio_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output logic      done_o,
  output cmd_t      cmd_o,
  input  wire sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: cmd_o.load = start;
      S_EXEC: begin
        cmd_o.match  = sts_i.is_search;
        cmd_o.commit = !sts_i.is_search;
      end
      S_SCAN: begin
        cmd_o.finish = sts_i.hit || sts_i.none;
        cmd_o.step   = !(sts_i.hit || sts_i.none);
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          if (sts_i.is_search) begin
            state_q <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        S_SCAN: begin
          if (sts_i.hit || sts_i.none) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.commit, cmd_o.match, cmd_o.step, cmd_o.finish}))
    else $error("olio_ctrl: more than one datapath command");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) == !busy_q)
    else $error("olio_ctrl: busy disagrees with state");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("olio_ctrl: done held two cycles");

endmodule

`default_nettype wire

### hdl/olio_dp.sv
// ----------------------------------------------------------------------------
// olio_dp
// Entry registers, count, shift network, match vector and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module olio_dp
  import olio_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic [STATUS_W-1:0]      status_o,
  output logic [FOUND_W-1:0]       found_position_o,
  output logic [TOTAL_W-1:0]       entry_total_o
);

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IXW = $clog2(DEPTH);
  localparam int unsigned W   = (CW > POS_W) ? CW : POS_W;

  logic [ACTION_W-1:0] act_q;
  logic [POS_W-1:0]    pos_q;
  logic [VALUE_W-1:0]  val_q;
  logic [CW-1:0]       count_q, count_d;
  logic [IXW-1:0]      idx_q;
  logic [DEPTH-1:0]    match_q, match_d;
  logic [VALUE_W-1:0]  ent [DEPTH];

  logic [STATUS_W-1:0] res_status_q;
  logic [FOUND_W-1:0]  res_found_q;
  logic [TOTAL_W-1:0]  res_total_q;

  logic [W-1:0] at_w, cnt_w;
  logic         is_ins, is_del, full, empty, ins_ok, del_ok;
  status_e      status_d;

  always_comb begin
    is_ins = (action_e'(act_q) == ACT_INS_HEAD) || (action_e'(act_q) == ACT_INS_AT);
    is_del = (action_e'(act_q) == ACT_DEL_HEAD) || (action_e'(act_q) == ACT_DEL_AT);
    at_w   = ((action_e'(act_q) == ACT_INS_AT) || (action_e'(act_q) == ACT_DEL_AT))
             ? W'(pos_q) : '0;
    cnt_w  = W'(count_q);
    full   = (count_q == CW'(DEPTH));
    empty  = (count_q == '0);
    case (action_e'(act_q))
      ACT_INS_HEAD, ACT_INS_AT: begin
        if (full)              status_d = ST_FULL;
        else if (at_w > cnt_w) status_d = ST_RANGE;
        else                   status_d = ST_OK;
      end
      ACT_DEL_HEAD, ACT_DEL_AT: begin
        if (empty)              status_d = ST_EMPTY;
        else if (at_w >= cnt_w) status_d = ST_RANGE;
        else                    status_d = ST_OK;
      end
      default: status_d = ST_OK;
    endcase
    ins_ok  = cmd_i.commit && is_ins && (status_d == ST_OK);
    del_ok  = cmd_i.commit && is_del && (status_d == ST_OK);
    count_d = count_q;
    if (ins_ok)      count_d = count_q + 1'b1;
    else if (del_ok) count_d = count_q - 1'b1;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_ent
    localparam logic [W-1:0] G = W'(g);
    logic [VALUE_W-1:0] ent_q;
    logic [VALUE_W-1:0] prev, next;

    if (g == 0) begin : g_head
      assign prev = val_q;
    end else begin : g_body
      assign prev = ent[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next = ent_q;
    end else begin : g_mid
      assign next = ent[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (ins_ok && (G == at_w)) begin
        ent_q <= val_q;
      end else if (ins_ok && (G > at_w) && (G <= cnt_w)) begin
        ent_q <= prev;
      end else if (del_ok && (G >= at_w) && ((G + 1'b1) < cnt_w)) begin
        ent_q <= next;
      end
    end

    assign ent[g]     = ent_q;
    assign match_d[g] = (ent_q == val_q) && (G < cnt_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.match) begin
      match_q <= match_d;
      idx_q   <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.commit) begin
      res_status_q <= status_d;
      res_found_q  <= NOT_FOUND;
      res_total_q  <= TOTAL_W'(count_d);
    end else if (cmd_i.finish) begin
      res_status_q <= ST_OK;
      res_found_q  <= sts_o.hit ? FOUND_W'(idx_q) : NOT_FOUND;
      res_total_q  <= TOTAL_W'(count_q);
    end
  end

  assign sts_o.is_search = (action_e'(act_q) == ACT_SEARCH);
  assign sts_o.hit       = match_q[idx_q];
  assign sts_o.none      = ~|match_q;

  assign status_o         = res_status_q;
  assign found_position_o = res_found_q;
  assign entry_total_o    = res_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("olio_dp: entry count beyond depth");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (status_d != ST_OK)) |=> $stable(count_q))
    else $error("olio_dp: rejected request changed the count");

endmodule

`default_nettype wire

### hdl/ordered_list_index_ops.sv
// ----------------------------------------------------------------------------
// ordered_list_index_ops
// Ordered list of signed 32-bit values with insert, delete and search.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat is taken on a rising edge with start high and busy low;
//   action_i, position_i and value_i are sampled on that edge. busy rises
//   on the next cycle and stays high until the result is issued.
//   Each request yields one result beat: result_valid_o is high for exactly
//   one cycle with status_o, found_position_o and entry_total_o.
// Operation:
//   insert and delete: the shift network updates all entries in parallel
//   and the result is registered from the execute state.
//   search: the match vector is built in the execute state and then
//   scanned one index per cycle from index 0; the result holds the first
//   match, or NOT_FOUND when nothing matches.
//   A new request is taken on the cycle the result is shown.
// Reset: the list is empty after reset; entry contents are not cleared.
// The receiver cannot stall: a result beat is taken in its one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_index_ops
  import olio_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic signed [VALUE_W-1:0] value_i,
  output logic                     result_valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [FOUND_W-1:0] found_position_o,
  output logic [TOTAL_W-1:0]       entry_total_o
);

  cmd_t cmd;
  sts_t sts;

  logic [FOUND_W-1:0] found_pos;

  olio_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (result_valid_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  olio_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .status_o         (status_o),
    .found_position_o (found_pos),
    .entry_total_o    (entry_total_o)
  );

  assign found_position_o = found_pos;

endmodule

`default_nettype wire

### tb/tb_ordered_list_index_ops.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_index_ops
// Self-checking bench for the ordered list with insert, delete and search.
// A shadow copy of the list predicts status, match index and entry count for
// every request beat the block takes, and each result beat is checked against
// the oldest prediction. A short directed sequence hits the empty and
// out-of-range cases. Random traffic then alternates between stretches that
// fill the list and stretches that drain it, under three sender idle
// profiles.
// ----------------------------------------------------------------------------

module tb_ordered_list_index_ops;
  import olio_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 16;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 480;
  localparam int STRETCH      = 40;
  localparam int REPORT_MAX   = 10;

  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    status_e                   status;
    logic signed [FOUND_W-1:0] found;
    logic [TOTAL_W-1:0]        total;
  } reply_t;

  class list_shadow;
    logic signed [VALUE_W-1:0] slots[LIST_DEPTH];
    int     fill = 0;
    int     mismatches = 0;
    reply_t pending_replies[$];

    function void note_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                               logic signed [VALUE_W-1:0] val);
      reply_t r;
      int     at;
      r.action = act;
      r.status = ST_OK;
      r.found  = NOT_FOUND;
      at = (act == ACT_INS_AT || act == ACT_DEL_AT) ? int'(pos) : 0;
      case (act)
        ACT_INS_HEAD, ACT_INS_AT: begin
          if (fill >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else if (at > fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = fill; i > at; i--) slots[i] = slots[i-1];
            slots[at] = val;
            fill++;
          end
        end
        ACT_DEL_HEAD, ACT_DEL_AT: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (at >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (int i = at; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
        ACT_SEARCH: begin
          for (int i = fill - 1; i >= 0; i--) begin
            if (slots[i] == val) r.found = FOUND_W'(i);
          end
        end
        default: begin
        end
      endcase
      r.total = TOTAL_W'(fill);
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic signed [FOUND_W-1:0] fp,
                               logic [TOTAL_W-1:0] tot);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with no request waiting: status %0d found %0d total %0d",
                   $realtime, st, fp, tot);
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || fp !== want.found || tot !== want.total) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: action %0d mismatch: status %0d/%0d found %0d/%0d total %0d/%0d",
                   $realtime, want.action, st, want.status, fp, want.found,
                   tot, want.total);
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic [ACTION_W-1:0]       action_i = '0;
  logic [POS_W-1:0]          position_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      busy;
  logic                      result_valid_o;
  logic [STATUS_W-1:0]       status_o;
  logic signed [FOUND_W-1:0] found_position_o;
  logic [TOTAL_W-1:0]        entry_total_o;

  list_shadow shadow;
  int         quiet_cycles = 0;

  ordered_list_index_ops #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .found_position_o(found_position_o),
    .entry_total_o   (entry_total_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) shadow.check_result(status_o, found_position_o, entry_total_o);
      if (start && !busy) shadow.note_request(action_i, position_i, value_i);
      if (result_valid_o || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("** ordered_list_index_ops: FAILED **");
    $finish;
  end

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [POS_W-1:0] pos,
                              input logic signed [VALUE_W-1:0] val);
    start      <= 1'b1;
    action_i   <= act;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VALUE_W-1:0] any_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return $signed($urandom_range(0, 8)) - 32'sd4;
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic random_request(input int idle_pct, input bit grow);
    int                        roll;
    int                        ins_pct;
    int                        del_pct;
    int                        fill;
    logic [ACTION_W-1:0]       act;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    fill    = shadow.fill;
    ins_pct = grow ? 55 : 20;
    del_pct = grow ? 15 : 50;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) act = roll[0] ? ACT_INS_AT : ACT_INS_HEAD;
    else if (roll < ins_pct + del_pct) act = roll[0] ? ACT_DEL_AT : ACT_DEL_HEAD;
    else if (roll < 95) act = ACT_SEARCH;
    else act = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));

    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      if (act == ACT_DEL_AT) pos = POS_W'($urandom_range(0, (fill > 0) ? fill - 1 : 0));
      else pos = POS_W'($urandom_range(0, fill));
    end else if (roll < 9) begin
      pos = POS_W'($urandom_range(0, 31));
    end else begin
      pos = (act == ACT_DEL_AT) ? POS_W'(fill) : POS_W'(fill + 1);
    end

    if (act == ACT_SEARCH && fill > 0 && $urandom_range(0, 9) < 6)
      val = shadow.slots[$urandom_range(0, fill - 1)];
    else
      val = any_value();

    if ($urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 12));
    send_request(act, pos, val);
  endtask

  initial begin
    int idle_pct;
    shadow = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_request(ACT_SEARCH, 5'd0, 32'sd0);
    send_request(ACT_DEL_HEAD, 5'd0, 32'sd0);
    send_request(ACT_DEL_AT, 5'd31, 32'sd0);
    send_request(ACT_INS_AT, 5'd1, 32'sd9);
    send_request(ACT_INS_AT, 5'd0, 32'h8000_0000);
    send_request(ACT_INS_HEAD, 5'd31, 32'h7fff_ffff);
    send_request(ACT_INS_AT, 5'd2, -32'sd1);
    send_request(ACT_INS_AT, 5'd31, 32'sd5);
    send_request(ACT_INS_AT, 5'd4, 32'sd5);
    send_request(ACT_SEARCH, 5'd0, 32'h8000_0000);
    send_request(ACT_SEARCH, 5'd0, -32'sd1);
    send_request(ACT_SEARCH, 5'd0, 32'sd12345);
    send_request(ACT_DEL_AT, 5'd3, 32'sd0);
    send_request(ACT_DEL_AT, 5'd0, 32'sd0);
    send_request(ACT_DEL_AT, 5'd1, 32'sd0);
    for (int a = int'(ACT_UNUSED_LO); a <= int'(ACT_UNUSED_HI); a++)
      send_request(ACTION_W'(a), 5'd16, 32'h5a5a_a5a5);
    send_request(ACT_INS_HEAD, 5'd0, 32'sd7);
    send_request(ACT_INS_AT, 5'd2, 32'sd7);
    send_request(ACT_SEARCH, 5'd0, 32'sd7);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 10 : (ph == 1) ? 57 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++)
        random_request(idle_pct, ((n / STRETCH) % 2) == 0);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending_replies.size() == 0) begin
      $display("** ordered_list_index_ops: PASSED **");
    end else begin
      $display("** ordered_list_index_ops: FAILED **");
    end
    $finish;
  end

endmodule
